### hdl/tpcb_pkg.sv
// ---------------------------------------------------------------------------
// tpcb_pkg: shared definitions for the transparent pixel color bleed block
// Field widths, register indexes, opcodes, window tap codes and the
// command/status structs between the controller and the datapath.
// ---------------------------------------------------------------------------
package tpcb_pkg;

  // Default line store capacity in pixels per row.
  localparam int MAX_WIDTH_DEFAULT = 1024;

  // Pixel fields.
  localparam int COLOR_W  = 8;
  localparam int PIXEL_W  = 4 * COLOR_W;
  localparam int OPCODE_W = 1;

  // Opcodes of an input request.
  localparam logic [OPCODE_W-1:0] OP_PIXEL = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_FLUSH = 1'b1;

  // Configuration port.
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 1;
  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 16;
  localparam int IMAGE_WIDTH_RESET = 1024;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // 3x3 window taps, raster order, center in the middle.
  localparam int TAP_W    = 4;
  localparam int NUM_TAPS = 9;
  localparam logic [TAP_W-1:0] TAP_UP_LEFT    = 4'd0;
  localparam logic [TAP_W-1:0] TAP_UP         = 4'd1;
  localparam logic [TAP_W-1:0] TAP_UP_RIGHT   = 4'd2;
  localparam logic [TAP_W-1:0] TAP_LEFT       = 4'd3;
  localparam logic [TAP_W-1:0] TAP_CENTER     = 4'd4;
  localparam logic [TAP_W-1:0] TAP_RIGHT      = 4'd5;
  localparam logic [TAP_W-1:0] TAP_DOWN_LEFT  = 4'd6;
  localparam logic [TAP_W-1:0] TAP_DOWN       = 4'd7;
  localparam logic [TAP_W-1:0] TAP_DOWN_RIGHT = 4'd8;

  // Neighbor sums, count and the bit-serial divider.
  localparam int SUM_W     = 11;
  localparam int CNT_W     = 4;
  localparam int REM_W     = 3;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             take;
    logic             read_en;
    logic [TAP_W-1:0] tap;
    logic             div_step;
    logic             deliver;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_req;
    logic out_full;
  } status_t;

endpackage

### hdl/transparent_pixel_color_bleed_top.sv
// ---------------------------------------------------------------------------
// transparent_pixel_color_bleed_top: 3x3 alpha bleed filter
// Replaces the color of fully transparent pixels with the mean color of
// their opaque neighbors, streaming one frame in raster order.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in_valid/in_ready channel with opcode OP_PIXEL; after
//   the frame's last pixel, send one flush request (opcode OP_FLUSH) for each
//   pending pixel: width+1 of them, or the whole frame if it is smaller.
//   Results leave on out_valid/out_ready in raster order; last_pixel marks
//   the final pixel of the frame.
//   Program image_width (index 0) and image_height (index 1) through
//   cfg_write_en/cfg_index/cfg_data while the block is idle; a write restarts
//   the frame.
//   A request that yields no result leaves the block ready for the next one.
//   A request that yields a result holds the input through nine reads
//   through the single read port of the pixel ring, the addition of the
//   last tap and eleven steps of the bit-serial divider, then until the
//   result moves into the output register.
//   Reset restores width 1024 and height 1 and empties the frame; the ring
//   needs no clearing pass. When the receiver stalls, the result waits in the
//   output register while the next request is taken; a further result waits
//   inside the block until the register frees.
// ---------------------------------------------------------------------------
module transparent_pixel_color_bleed_top #(
  parameter int MAX_WIDTH = tpcb_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tpcb_pkg::OPCODE_W-1:0]    opcode,
  input  logic [tpcb_pkg::COLOR_W-1:0]     red_in,
  input  logic [tpcb_pkg::COLOR_W-1:0]     green_in,
  input  logic [tpcb_pkg::COLOR_W-1:0]     blue_in,
  input  logic [tpcb_pkg::COLOR_W-1:0]     alpha_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tpcb_pkg::COLOR_W-1:0]     red_out,
  output logic [tpcb_pkg::COLOR_W-1:0]     green_out,
  output logic [tpcb_pkg::COLOR_W-1:0]     blue_out,
  output logic [tpcb_pkg::COLOR_W-1:0]     alpha_out,
  output logic                             last_pixel,
  input  logic                             cfg_write_en,
  input  logic [tpcb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tpcb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import tpcb_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  tpcb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // Line store, counters, accumulator, divider and output register.
  tpcb_datapath #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .opcode      (opcode),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .alpha_in    (alpha_in),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .alpha_out   (alpha_out),
    .last_pixel  (last_pixel)
  );

endmodule

### hdl/tpcb_ram.sv
// ---------------------------------------------------------------------------
// tpcb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module tpcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/tpcb_ctrl.sv
// ---------------------------------------------------------------------------
// tpcb_ctrl: sequencer for the color bleed block
// Accepts requests, walks the nine window taps through the line store read
// port, runs the divider and hands the result to the output register.
// ---------------------------------------------------------------------------
module tpcb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpcb_pkg::status_t status,
  output tpcb_pkg::cmd_t    cmd
);

  import tpcb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && status.emit_req) begin
          state_next = S_READ;
          step_next  = '0;
        end
      end
      S_READ: begin
        // One tap read per cycle, then a final step to add the last tap.
        cmd.read_en = (step < STEP_W'(NUM_TAPS));
        cmd.tap     = TAP_W'(step);
        if (step == STEP_W'(NUM_TAPS)) begin
          state_next = S_DIV;
          step_next  = '0;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_OUT;
          step_next  = '0;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_OUT: begin
        if (!status.out_full) begin
          cmd.deliver = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        step_next  = '0;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // The tap walk starts only from a request that needs a result.
  ap_read_after_take: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && step == '0) |-> $past(cmd.take && status.emit_req))
    else $error("tap walk started without an emitting request");

  // The output stage is reached only after the divider has run.
  ap_out_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && $past(state) != S_OUT) |-> $past(cmd.div_step))
    else $error("result stage entered without a divide step");

endmodule

### hdl/tpcb_datapath.sv
// ---------------------------------------------------------------------------
// tpcb_datapath: line store, position counters, accumulator and divider
// Holds the ring of recent pixels, tracks the frame position of the next
// input and of the next result, sums the opaque neighbors and divides.
// ---------------------------------------------------------------------------
module tpcb_datapath #(
  parameter int MAX_WIDTH = tpcb_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [tpcb_pkg::OPCODE_W-1:0]    opcode,
  input  logic [tpcb_pkg::COLOR_W-1:0]     red_in,
  input  logic [tpcb_pkg::COLOR_W-1:0]     green_in,
  input  logic [tpcb_pkg::COLOR_W-1:0]     blue_in,
  input  logic [tpcb_pkg::COLOR_W-1:0]     alpha_in,
  input  logic                             cfg_write_en,
  input  logic [tpcb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tpcb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  tpcb_pkg::cmd_t                   cmd,
  output tpcb_pkg::status_t                status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [tpcb_pkg::COLOR_W-1:0]     red_out,
  output logic [tpcb_pkg::COLOR_W-1:0]     green_out,
  output logic [tpcb_pkg::COLOR_W-1:0]     blue_out,
  output logic [tpcb_pkg::COLOR_W-1:0]     alpha_out,
  output logic                             last_pixel
);

  import tpcb_pkg::*;

  localparam int RING    = 2 * MAX_WIDTH + 4;
  localparam int AW      = $clog2(RING);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int PW      = $clog2(MAX_WIDTH + 2);
  localparam int HW      = IMAGE_HEIGHT_W;
  localparam int W_RESET = (MAX_WIDTH < IMAGE_WIDTH_RESET) ? MAX_WIDTH : IMAGE_WIDTH_RESET;

  typedef struct packed {
    logic [SUM_W-1:0] quo;
    logic [REM_W-1:0] rem;
  } div_t;

  // One restoring division step: next quotient bit shifted into the sum.
  function automatic div_t div_bit(input logic [SUM_W-1:0] num,
                                   input logic [REM_W-1:0] rem,
                                   input logic [CNT_W-1:0] den);
    logic [REM_W:0] trial;
    div_t           res;
    trial = {rem, num[SUM_W-1]};
    if (trial >= den) begin
      res.quo = {num[SUM_W-2:0], 1'b1};
      res.rem = REM_W'(trial - den);
    end else begin
      res.quo = {num[SUM_W-2:0], 1'b0};
      res.rem = trial[REM_W-1:0];
    end
    return res;
  endfunction

  // Configuration and frame position.
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [WW-1:0] w_cfg;
  logic [HW-1:0] h_cfg;
  logic          cfg_hit;
  logic [CW-1:0] col;
  logic [HW-1:0] row;
  logic [PW-1:0] pending;
  logic [AW-1:0] wp;
  logic [AW-1:0] cp;
  logic [CW-1:0] ex;
  logic [HW-1:0] ey;
  logic          drain_q;

  // Request decode.
  logic row_open;
  logic pend_full;
  logic pix_ok;
  logic flush_ok;
  logic col_wrap;
  logic ex_wrap;
  logic ex_first;
  logic ex_last;
  logic ey_first;
  logic ey_last;
  logic [AW-1:0] wp_inc;
  logic [AW-1:0] cp_inc;
  logic [AW:0]   wp_plus;
  logic [AW:0]   cp_plus;

  // Tap address and read pipeline.
  logic [AW:0]        ring_c;
  logic [AW:0]        wx;
  logic [AW:0]        tap_off;
  logic [AW:0]        tap_sum;
  logic [AW-1:0]      rd_addr;
  logic               nb_ok;
  logic               rd_valid_q;
  logic [TAP_W-1:0]   rd_tap_q;
  logic               rd_inimg_q;
  logic [PIXEL_W-1:0] rd_data;

  // Accumulator and divider.
  logic [PIXEL_W-1:0] centre;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_g;
  logic [SUM_W-1:0]   sum_b;
  logic [REM_W-1:0]   rem_r;
  logic [REM_W-1:0]   rem_g;
  logic [REM_W-1:0]   rem_b;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   divisor;
  div_t               div_r;
  div_t               div_g;
  div_t               div_b;

  // Effective width and height from the written register values.
  always_comb begin
    if (cfg_data[IMAGE_WIDTH_W-1:0] == '0) begin
      w_cfg = WW'(1);
    end else if (int'(cfg_data[IMAGE_WIDTH_W-1:0]) > MAX_WIDTH) begin
      w_cfg = WW'(MAX_WIDTH);
    end else begin
      w_cfg = WW'(cfg_data[IMAGE_WIDTH_W-1:0]);
    end
    h_cfg = (cfg_data[IMAGE_HEIGHT_W-1:0] == '0) ? HW'(1) : cfg_data[IMAGE_HEIGHT_W-1:0];
  end

  assign cfg_hit = cfg_write_en &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= WW'(W_RESET);
      h_eff <= HW'(1);
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  w_eff <= w_cfg;
        REG_IMAGE_HEIGHT: h_eff <= h_cfg;
        default: begin
        end
      endcase
    end
  end

  // Decode of the request at the input.
  assign row_open  = (row < h_eff);
  assign pend_full = (pending == PW'(w_eff) + PW'(1));
  assign pix_ok    = (opcode == OP_PIXEL) && row_open;
  assign flush_ok  = (opcode == OP_FLUSH) && !row_open && (pending != '0);
  assign status.emit_req = (pix_ok && pend_full) || flush_ok;
  assign status.out_full = out_valid && !out_ready;

  assign col_wrap = (WW'(col) + WW'(1)) == w_eff;
  assign ex_wrap  = (WW'(ex) + WW'(1)) == w_eff;
  assign ex_first = (ex == '0);
  assign ex_last  = (WW'(ex) == w_eff - WW'(1));
  assign ey_first = (ey == '0);
  assign ey_last  = (ey == h_eff - HW'(1));

  // Ring pointers wrap at the ring size.
  assign ring_c  = (AW+1)'(RING);
  assign wp_plus = {1'b0, wp} + (AW+1)'(1);
  assign cp_plus = {1'b0, cp} + (AW+1)'(1);
  assign wp_inc  = (wp_plus == ring_c) ? '0 : wp_plus[AW-1:0];
  assign cp_inc  = (cp_plus == ring_c) ? '0 : cp_plus[AW-1:0];

  // Frame counters: input position, result position and pending count.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col     <= '0;
      row     <= '0;
      pending <= '0;
      wp      <= '0;
      cp      <= '0;
      ex      <= '0;
      ey      <= '0;
      drain_q <= 1'b0;
    end else begin
      if (cmd.take && pix_ok) begin
        wp <= wp_inc;
        if (col_wrap) begin
          col <= '0;
          row <= row + HW'(1);
        end else begin
          col <= col + CW'(1);
        end
        if (!pend_full) begin
          pending <= pending + PW'(1);
        end
      end
      if (cmd.take && flush_ok) begin
        pending <= pending - PW'(1);
      end
      if (cmd.take) begin
        drain_q <= flush_ok && (pending == PW'(1));
      end
      if (cmd.deliver) begin
        if (drain_q) begin
          // Last pending pixel is out: the next pixel starts a new frame.
          col     <= '0;
          row     <= '0;
          pending <= '0;
          wp      <= '0;
          cp      <= '0;
          ex      <= '0;
          ey      <= '0;
          drain_q <= 1'b0;
        end else begin
          cp <= cp_inc;
          if (ex_wrap) begin
            ex <= '0;
            ey <= ey + HW'(1);
          end else begin
            ex <= ex + CW'(1);
          end
        end
      end
    end
  end

  // Ring offset and image bounds for the current tap.
  assign wx = (AW+1)'(w_eff);

  always_comb begin
    tap_off = '0;
    nb_ok   = 1'b1;
    case (cmd.tap)
      TAP_UP_LEFT: begin
        tap_off = ring_c - wx - (AW+1)'(1);
        nb_ok   = !ex_first && !ey_first;
      end
      TAP_UP: begin
        tap_off = ring_c - wx;
        nb_ok   = !ey_first;
      end
      TAP_UP_RIGHT: begin
        tap_off = ring_c - wx + (AW+1)'(1);
        nb_ok   = !ex_last && !ey_first;
      end
      TAP_LEFT: begin
        tap_off = ring_c - (AW+1)'(1);
        nb_ok   = !ex_first;
      end
      TAP_CENTER: begin
        tap_off = '0;
        nb_ok   = 1'b1;
      end
      TAP_RIGHT: begin
        tap_off = (AW+1)'(1);
        nb_ok   = !ex_last;
      end
      TAP_DOWN_LEFT: begin
        tap_off = wx - (AW+1)'(1);
        nb_ok   = !ex_first && !ey_last;
      end
      TAP_DOWN: begin
        tap_off = wx;
        nb_ok   = !ey_last;
      end
      TAP_DOWN_RIGHT: begin
        tap_off = wx + (AW+1)'(1);
        nb_ok   = !ex_last && !ey_last;
      end
      default: begin
        tap_off = '0;
        nb_ok   = 1'b0;
      end
    endcase
    tap_sum = {1'b0, cp} + tap_off;
    if (tap_sum >= ring_c) begin
      tap_sum = tap_sum - ring_c;
    end
  end

  assign rd_addr = tap_sum[AW-1:0];

  // Ring of recent pixels.
  tpcb_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(RING)
  ) u_ring (
    .clk    (clk),
    .wr_en  (cmd.take && pix_ok),
    .wr_addr(wp),
    .wr_data({red_in, green_in, blue_in, alpha_in}),
    .rd_en  (cmd.read_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Tap tag travels alongside the registered read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd.read_en;
    end
    rd_tap_q   <= cmd.tap;
    rd_inimg_q <= nb_ok;
  end

  // Divider lanes, one per color.
  assign divisor = (count == '0) ? CNT_W'(1) : count;
  assign div_r   = div_bit(sum_r, rem_r, divisor);
  assign div_g   = div_bit(sum_g, rem_g, divisor);
  assign div_b   = div_bit(sum_b, rem_b, divisor);

  // Neighbor accumulation, then the sums are divided in place.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      rem_r <= '0;
      rem_g <= '0;
      rem_b <= '0;
      count <= '0;
    end else if (rd_valid_q) begin
      if (rd_tap_q == TAP_CENTER) begin
        centre <= rd_data;
      end else if (rd_inimg_q && rd_data[COLOR_W-1:0] != '0) begin
        sum_r <= sum_r + SUM_W'(rd_data[4*COLOR_W-1:3*COLOR_W]);
        sum_g <= sum_g + SUM_W'(rd_data[3*COLOR_W-1:2*COLOR_W]);
        sum_b <= sum_b + SUM_W'(rd_data[2*COLOR_W-1:COLOR_W]);
        count <= count + CNT_W'(1);
      end
    end else if (cmd.div_step) begin
      sum_r <= div_r.quo;
      sum_g <= div_g.quo;
      sum_b <= div_b.quo;
      rem_r <= div_r.rem;
      rem_g <= div_g.rem;
      rem_b <= div_b.rem;
    end
  end

  // Output register: holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      if (centre[COLOR_W-1:0] == '0) begin
        red_out   <= sum_r[COLOR_W-1:0];
        green_out <= sum_g[COLOR_W-1:0];
        blue_out  <= sum_b[COLOR_W-1:0];
      end else begin
        red_out   <= centre[4*COLOR_W-1:3*COLOR_W];
        green_out <= centre[3*COLOR_W-1:2*COLOR_W];
        blue_out  <= centre[2*COLOR_W-1:COLOR_W];
      end
      alpha_out  <= centre[COLOR_W-1:0];
      last_pixel <= ex_last && ey_last;
    end
  end

  // The pending count never runs past one row plus one pixel.
  ap_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PW'(w_eff) + PW'(1))
    else $error("pending count beyond one row plus one pixel");

  // A new result appears only through a delivery from the sequencer.
  ap_out_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.deliver))
    else $error("output valid rose without a delivery");

  // Draining the final pixel returns every position to the frame start.
  ap_drain_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.deliver && drain_q) |=> (pending == '0 && row == '0 && col == '0 && cp == '0))
    else $error("frame not restarted after the last pixel");

endmodule

### tb/sv/transparent_pixel_color_bleed_top_tb.sv
// ---------------------------------------------------------------------------
// transparent_pixel_color_bleed_top_tb: self-checking bench for the bleed filter
// Streams RGBA frames and flush requests into the block and predicts every
// result with an independent 3x3 neighbor-average model. Each result is
// compared field by field with the oldest prediction. Both channels idle and
// stall at random, and one long output stall fills the block.
// ---------------------------------------------------------------------------
module transparent_pixel_color_bleed_top_tb;
  import tpcb_pkg::*;

  // Pixel ring of the predictor: large enough for two lines plus margin.
  localparam int RING_DEPTH = 2 * (MAX_WIDTH_DEFAULT + 2);
  // Cycles to let a request in progress finish before the block counts as idle.
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [COLOR_W-1:0]  alpha;
  } pixel_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
    logic               last_flag;
  } bled_pixel_t;

  // How a random frame deviates from a clean pixel run plus drain.
  typedef enum int {
    FRAME_CLEAN,
    FRAME_EARLY_FLUSH,
    FRAME_OVERRUN,
    FRAME_EXTRA_FLUSH,
    FRAME_ABANDON
  } frame_style_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [OPCODE_W-1:0]    opcode;
  logic [COLOR_W-1:0]     red_in;
  logic [COLOR_W-1:0]     green_in;
  logic [COLOR_W-1:0]     blue_in;
  logic [COLOR_W-1:0]     alpha_in;
  logic                   out_valid;
  logic                   out_ready;
  logic [COLOR_W-1:0]     red_out;
  logic [COLOR_W-1:0]     green_out;
  logic [COLOR_W-1:0]     blue_out;
  logic [COLOR_W-1:0]     alpha_out;
  logic                   last_pixel;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Predictor state: registers, frame position and recent input pixels.
  logic [IMAGE_WIDTH_W-1:0]  width_reg;
  logic [IMAGE_HEIGHT_W-1:0] height_reg;
  int unsigned               frame_col;
  int unsigned               frame_row;
  int unsigned               pending_pixels;
  logic [PIXEL_W-1:0]        ring_mem [RING_DEPTH];

  bled_pixel_t expected_pixels [$];
  int          error_count;
  int          sender_idle_mode;
  int          receiver_idle_mode;
  int          hold_off_request;

  transparent_pixel_color_bleed_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .alpha_in     (alpha_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .alpha_out    (alpha_out),
    .last_pixel   (last_pixel),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Effective frame size after clamping the registers.
  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_frame();
    frame_col = 0;
    frame_row = 0;
    pending_pixels = 0;
  endfunction

  // Output pixel at raster position k: transparent pixels take the truncated
  // mean color of their opaque in-image neighbors, or zero if there are none.
  function automatic bled_pixel_t bleed_at(input int unsigned k, input int unsigned w,
                                           input int unsigned h);
    bled_pixel_t        px;
    logic [PIXEL_W-1:0] centre;
    logic [PIXEL_W-1:0] word;
    int unsigned        sum_r;
    int unsigned        sum_g;
    int unsigned        sum_b;
    int unsigned        opaque_n;
    int                 x;
    int                 y;
    int                 nx;
    int                 ny;
    x = k % w;
    y = k / w;
    centre = ring_mem[k % RING_DEPTH];
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    opaque_n = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nx = x + dx;
        ny = y + dy;
        if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < int'(w) && ny < int'(h)) begin
          word = ring_mem[(ny * int'(w) + nx) % RING_DEPTH];
          if (word[7:0] != 0) begin
            sum_r += word[31:24];
            sum_g += word[23:16];
            sum_b += word[15:8];
            opaque_n++;
          end
        end
      end
    end
    px.red = centre[31:24];
    px.green = centre[23:16];
    px.blue = centre[15:8];
    px.alpha = centre[7:0];
    if (px.alpha == 0) begin
      if (opaque_n == 0) opaque_n = 1;
      px.red = COLOR_W'(sum_r / opaque_n);
      px.green = COLOR_W'(sum_g / opaque_n);
      px.blue = COLOR_W'(sum_b / opaque_n);
    end
    px.last_flag = (k == w * h - 1);
    return px;
  endfunction

  // Update the predictor for one accepted request and queue its result.
  function automatic void advance_frame(input pixel_req_t req);
    int unsigned w;
    int unsigned h;
    int unsigned received;
    w = active_width();
    h = active_height();
    received = frame_row * w + frame_col;
    if (req.op == OP_PIXEL) begin
      // A pixel past the end of the frame is dropped.
      if (frame_row >= h) return;
      ring_mem[received % RING_DEPTH] = {req.red, req.green, req.blue, req.alpha};
      received++;
      frame_col++;
      if (frame_col >= w) begin
        frame_col = 0;
        frame_row++;
      end
      pending_pixels++;
      if (pending_pixels > w + 1) begin
        pending_pixels--;
        expected_pixels.push_back(bleed_at(received - w - 2, w, h));
      end
    end else if (frame_row >= h && pending_pixels != 0) begin
      expected_pixels.push_back(bleed_at(w * h - pending_pixels, w, h));
      pending_pixels--;
      if (pending_pixels == 0) restart_frame();
    end
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int idle_gap(input int mode);
    int roll;
    if (mode == 0) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic pixel_req_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [7:0] a);
    pixel_req_t req;
    req.op = OP_PIXEL;
    req.red = r;
    req.green = g;
    req.blue = b;
    req.alpha = a;
    return req;
  endfunction

  // Random pixel with a strong share of transparent ones.
  function automatic pixel_req_t random_pixel();
    logic [7:0] a;
    case ($urandom_range(9))
      0, 1, 2, 3: a = 8'd0;
      4:          a = 8'hFF;
      default:    a = 8'($urandom_range(255, 1));
    endcase
    return make_pixel(8'($urandom), 8'($urandom), 8'($urandom), a);
  endfunction

  // Flush request; its color fields carry junk that the block must ignore.
  function automatic pixel_req_t flush_request();
    pixel_req_t req;
    req = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    req.op = OP_FLUSH;
    return req;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(input pixel_req_t req);
    int gap;
    gap = idle_gap(sender_idle_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= req.op;
    red_in <= req.red;
    green_in <= req.green;
    blue_in <= req.blue;
    alpha_in <= req.alpha;
    do @(posedge clk); while (!in_ready);
    advance_frame(req);
  endtask

  // Stop offering requests and wait until the block has nothing left to do.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    wait_until_drained();
    cfg_write_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (index == REG_IMAGE_WIDTH) width_reg = data[IMAGE_WIDTH_W-1:0];
    else height_reg = data[IMAGE_HEIGHT_W-1:0];
    restart_frame();
  endtask

  // Program both registers in random order.
  task automatic configure_frame(input logic [CFG_DATA_W-1:0] width_data,
                                 input logic [CFG_DATA_W-1:0] height_data);
    if ($urandom_range(1) == 0) begin
      write_register(REG_IMAGE_WIDTH, width_data);
      write_register(REG_IMAGE_HEIGHT, height_data);
    end else begin
      write_register(REG_IMAGE_HEIGHT, height_data);
      write_register(REG_IMAGE_WIDTH, width_data);
    end
  endtask

  // Reset geometry: flushes with no frame complete give nothing, and the
  // pixels sent here are abandoned by the next register write.
  task automatic test_reset_state();
    sender_idle_mode = 0;
    receiver_idle_mode = 0;
    send_request(flush_request());
    repeat (3) send_request(random_pixel());
    send_request(flush_request());
  endtask

  // A 3x3 frame covering full-scale sums, a pixel after the frame end and a
  // flush with nothing left.
  task automatic test_directed_neighborhood();
    configure_frame(16'd3, 16'd3);
    send_request(make_pixel(8'hAA, 8'h55, 8'h0F, 8'h00));
    send_request(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_pixel(8'h12, 8'h34, 8'h56, 8'h00));
    send_request(make_pixel(8'h00, 8'h00, 8'h00, 8'h01));
    send_request(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_request(make_pixel(8'hFF, 8'h00, 8'h80, 8'hC8));
    send_request(make_pixel(8'h07, 8'h08, 8'h09, 8'h80));
    send_request(make_pixel(8'h00, 8'hFF, 8'h00, 8'h00));
    send_request(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_pixel(8'h5A, 8'h5A, 8'h5A, 8'h5A));
    repeat (5) send_request(flush_request());
  endtask

  // Zero width and height both act as one; the transparent pixel has no
  // neighbors at all. The second frame starts without a register write.
  task automatic test_single_pixel();
    configure_frame(16'hF800, 16'h0000);
    send_request(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_request(flush_request());
    send_request(make_pixel(8'h81, 8'h42, 8'h24, 8'hFF));
    send_request(flush_request());
  endtask

  // Widest line with two rows, then the tallest frame; both are cut short.
  task automatic test_register_extremes();
    sender_idle_mode = 1;
    receiver_idle_mode = 1;
    configure_frame(16'hFFFF, 16'd2);
    repeat (MAX_WIDTH_DEFAULT + 6) send_request(random_pixel());
    configure_frame(16'd3, 16'hFFFF);
    repeat (40) send_request(random_pixel());
  endtask

  // The receiver holds off while the sender keeps going, so the input stalls.
  task automatic test_backpressure();
    configure_frame(16'd4, 16'd6);
    sender_idle_mode = 0;
    hold_off_request = 300;
    repeat (24) send_request(random_pixel());
    repeat (5) send_request(flush_request());
  endtask

  // Random small frames, mostly clean, some with stray or missing requests.
  // The earlier tests already send most of the run's requests.
  task automatic test_random_frames();
    int unsigned  items_sent;
    int unsigned  w;
    int unsigned  h;
    int unsigned  frame_px;
    int unsigned  pixel_n;
    int unsigned  drain_n;
    int unsigned  roll;
    frame_style_t style;
    bit           frame_open;
    items_sent = 0;
    frame_open = 1'b1;
    while (items_sent < 60) begin
      sender_idle_mode = ($urandom_range(2) != 0) ? 1 : 0;
      receiver_idle_mode = ($urandom_range(2) != 0) ? 1 : 0;
      roll = $urandom_range(99);
      if (roll < 75) w = $urandom_range(8, 1);
      else if (roll < 95) w = $urandom_range(40, 9);
      else w = $urandom_range(160, 41);
      h = (w > 40) ? $urandom_range(2, 1) : $urandom_range(6, 1);
      // A drained frame may be followed directly by the next one.
      if (frame_open || $urandom_range(9) < 7) begin
        configure_frame({5'($urandom), 11'(w)}, 16'(h));
      end else begin
        w = active_width();
        h = active_height();
      end
      roll = $urandom_range(99);
      if (roll < 72) style = FRAME_CLEAN;
      else if (roll < 79) style = FRAME_EARLY_FLUSH;
      else if (roll < 86) style = FRAME_OVERRUN;
      else if (roll < 93) style = FRAME_EXTRA_FLUSH;
      else style = FRAME_ABANDON;
      frame_px = w * h;
      pixel_n = (style == FRAME_ABANDON) ? $urandom_range(frame_px - 1, 0) : frame_px;
      for (int unsigned i = 0; i < pixel_n; i++) begin
        if (style == FRAME_EARLY_FLUSH && $urandom_range(3) == 0) begin
          send_request(flush_request());
          items_sent++;
        end
        send_request(random_pixel());
        items_sent++;
      end
      if (style == FRAME_ABANDON) begin
        frame_open = 1'b1;
      end else begin
        if (style == FRAME_OVERRUN) begin
          repeat ($urandom_range(3, 1)) send_request(random_pixel());
          items_sent += 2;
        end
        drain_n = (frame_px < w + 1) ? frame_px : w + 1;
        repeat (drain_n) send_request(flush_request());
        items_sent += drain_n;
        if (style == FRAME_EXTRA_FLUSH) begin
          repeat ($urandom_range(3, 1)) send_request(flush_request());
          items_sent += 2;
        end
        frame_open = 1'b0;
      end
    end
  endtask

  // Output side: random or forced stalls, and a check of every accepted result.
  initial begin : result_receiver
    int          stall_left;
    bled_pixel_t want;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result with no request pending: rgba %0d %0d %0d %0d last %0d",
                 red_out, green_out, blue_out, alpha_out, last_pixel);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red_out", want.red, red_out);
          check_field("green_out", want.green, green_out);
          check_field("blue_out", want.blue, blue_out);
          check_field("alpha_out", want.alpha, alpha_out);
          check_field("last_pixel", want.last_flag, last_pixel);
        end
      end
      if (hold_off_request > 0) begin
        stall_left = hold_off_request;
        hold_off_request = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = idle_gap(receiver_idle_mode);
      end
    end
  end

  initial begin : watchdog
    #12000000;
    $display("transparent_pixel_color_bleed_top test failed");
    $finish;
  end

  initial begin : test_sequence
    in_valid = 1'b0;
    opcode = OP_PIXEL;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    alpha_in = '0;
    cfg_write_en = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    error_count = 0;
    sender_idle_mode = 0;
    receiver_idle_mode = 0;
    hold_off_request = 0;
    width_reg = IMAGE_WIDTH_W'(IMAGE_WIDTH_RESET);
    height_reg = 1;
    restart_frame();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed_neighborhood();
    test_single_pixel();
    test_register_extremes();
    test_backpressure();
    test_random_frames();
    wait_until_drained();
    if (error_count == 0) begin
      $display("transparent_pixel_color_bleed_top test passed");
    end else begin
      $display("transparent_pixel_color_bleed_top test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/tpcb_pkg.sv
hdl/tpcb_ram.sv
hdl/tpcb_ctrl.sv
hdl/tpcb_datapath.sv
hdl/transparent_pixel_color_bleed_top.sv
tb/sv/transparent_pixel_color_bleed_top_tb.sv
